>>> hdl/srs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srs_pkg: shared types and constants of the stepper ramp sequencer
// Holds the delay width, reset values, register indexes, coil table and the
// sequencer state record.
// ---------------------------------------------------------------------------
package srs_pkg;

    localparam int DELAY_WIDTH   = 10;
    localparam int CFG_IDX_WIDTH = 2;

    localparam logic signed [DELAY_WIDTH-1:0] MAX_DELAY_RST = DELAY_WIDTH'(75);
    localparam logic signed [DELAY_WIDTH-1:0] MIN_DELAY_RST = DELAY_WIDTH'(-150);

    // largest positive value the tick counter may reach
    localparam logic [DELAY_WIDTH-1:0] COUNT_TOP = {1'b0, {(DELAY_WIDTH-1){1'b1}}};

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_DELAY = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_DELAY = CFG_IDX_WIDTH'(1);

    typedef struct packed {
        logic [DELAY_WIDTH-1:0]        tick_count;
        logic signed [DELAY_WIDTH-1:0] cur_delay;
        logic                          decel;
        logic                          active;
        logic [1:0]                    phase;
        logic [3:0]                    coil;
    } t_seq_state;

    // full-step coil patterns, one per phase
    function automatic logic [3:0] coil_of(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = 4'd9;
            2'd1:    pat = 4'd10;
            2'd2:    pat = 4'd6;
            default: pat = 4'd5;
        endcase
        return pat;
    endfunction

endpackage
`default_nettype wire

>>> hdl/stepper_ramp_sequencer_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stepper_ramp_sequencer_core: full-step stepper ramp generator
// Turns timer ticks into a four-phase coil sequence with a linear ramp.
// ---------------------------------------------------------------------------
// Each input request is one timer tick with the sampled restart button. The
// block takes one request per clock while the output side is not stalled,
// and returns exactly one result per request. The path is an input register
// followed by the state update, which writes the sequencer state and the
// result register in the same cycle; that single update step sets the rate
// of one tick per clock. A stalled output holds the result register and,
// behind it, the input register, so nothing is dropped. While running, the
// tick counter counts up to the current delay; on reaching it the next coil
// pattern (9, 10, 6, 5) is latched, the counter restarts and the delay moves
// one step toward min_delay, then turns and climbs back to max_delay, where
// the profile stops. A stopped block restarts on a tick with the button
// pressed, at max_delay and accelerating, without stepping on that tick.
// Registers: index 0 max_delay (reset 75), index 1 min_delay (reset
// -150), both signed; writes to other indexes are ignored. Write them only
// while idle.
// ---------------------------------------------------------------------------
module stepper_ramp_sequencer_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // tick requests
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic                                   i_button_pressed,
    // results
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [3:0]                                  o_coil_pattern,
    output logic                                        o_running,
    output logic                                        o_stepped,
    // configuration writes
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [srs_pkg::CFG_IDX_WIDTH-1:0]      i_cfg_index,
    input  wire logic signed [srs_pkg::DELAY_WIDTH-1:0] i_cfg_data
);
    import srs_pkg::*;

    logic signed [DELAY_WIDTH-1:0] r_max_delay;
    logic signed [DELAY_WIDTH-1:0] r_min_delay;

    logic       r_s1_valid;
    logic       r_s1_button;
    logic       s1_adv;
    logic       s1_fire;

    t_seq_state r_state;
    t_seq_state n_state;
    logic       n_stepped;

    logic       r_out_valid;
    logic [3:0] r_out_coil;
    logic       r_out_running;
    logic       r_out_stepped;

    // configuration is always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_delay <= MAX_DELAY_RST;
            r_min_delay <= MIN_DELAY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAX_DELAY: r_max_delay <= i_cfg_data;
                REG_MIN_DELAY: r_min_delay <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // the update stage advances whenever the result register is free or drains
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign o_in_ready = !r_s1_valid || s1_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_button <= i_button_pressed;
        end
    end

    srs_step u_step (
        .i_state     (r_state),
        .i_button    (r_s1_button),
        .i_max_delay (r_max_delay),
        .i_min_delay (r_min_delay),
        .o_state     (n_state),
        .o_stepped   (n_stepped)
    );

    // sequencer state: advance once per tick request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.tick_count <= '0;
            r_state.cur_delay  <= MAX_DELAY_RST;
            r_state.decel      <= 1'b0;
            r_state.active     <= 1'b1;
            r_state.phase      <= 2'd0;
            r_state.coil       <= 4'd0;
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_coil    <= n_state.coil;
            r_out_running <= n_state.active;
            r_out_stepped <= n_stepped;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_coil_pattern = r_out_coil;
    assign o_running      = r_out_running;
    assign o_stepped      = r_out_stepped;

`ifndef NO_ASSERTIONS
    // a stopped profile is always left in the accelerating direction
    a_stop_accel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.active |-> !r_state.decel)
        else $error("stopped with decelerating set");

    // a tick that begins stopped never steps
    a_no_step_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && !r_state.active |=> !r_out_stepped)
        else $error("step issued while stopped");

    // the phase advances exactly when a step is reported
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_state.phase == 2'($past(r_state.phase) + 2'(r_out_stepped)))
        else $error("phase out of step with stepped flag");

    // the coil latch holds the pattern of the phase just left, or nothing yet
    a_coil_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.coil == 4'd0 || r_state.coil == coil_of(r_state.phase - 2'd1))
        else $error("coil latch does not match phase");

    // the tick counter saturates at its top
    a_count_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.tick_count <= COUNT_TOP)
        else $error("tick counter above top");
`endif

endmodule
`default_nettype wire

>>> hdl/srs_step.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srs_step: next-state logic of the ramp sequencer
// Computes the state after one tick and whether a coil step was issued.
// ---------------------------------------------------------------------------
module srs_step (
    input  var srs_pkg::t_seq_state                     i_state,
    input  wire logic                                   i_button,
    input  wire logic signed [srs_pkg::DELAY_WIDTH-1:0] i_max_delay,
    input  wire logic signed [srs_pkg::DELAY_WIDTH-1:0] i_min_delay,
    output var srs_pkg::t_seq_state                     o_state,
    output logic                                        o_stepped
);
    import srs_pkg::*;

    logic [DELAY_WIDTH-1:0] tick_base;

    always_comb begin
        o_state   = i_state;
        o_stepped = 1'b0;
        tick_base = i_state.tick_count;
        if (i_state.active) begin
            if ($signed(i_state.tick_count) >= i_state.cur_delay) begin
                o_state.coil  = coil_of(i_state.phase);
                o_state.phase = i_state.phase + 2'd1;
                o_stepped     = 1'b1;
                if (!i_state.decel) begin
                    if (i_state.cur_delay > i_min_delay) begin
                        o_state.cur_delay = i_state.cur_delay - DELAY_WIDTH'(1);
                    end else begin
                        o_state.decel = 1'b1;
                    end
                end else begin
                    if (i_state.cur_delay < i_max_delay) begin
                        o_state.cur_delay = i_state.cur_delay + DELAY_WIDTH'(1);
                    end else begin
                        // ramp is back at the slow end: stop
                        o_state.decel  = 1'b0;
                        o_state.active = 1'b0;
                    end
                end
                tick_base = '0;
            end
            // saturate the counter at its top
            if (tick_base < COUNT_TOP) begin
                o_state.tick_count = tick_base + DELAY_WIDTH'(1);
            end else begin
                o_state.tick_count = tick_base;
            end
        end else if (i_button) begin
            // restart without stepping; phase and coil latch are kept
            o_state.cur_delay  = i_max_delay;
            o_state.tick_count = '0;
            o_state.decel      = 1'b0;
            o_state.active     = 1'b1;
        end
    end

endmodule
`default_nettype wire

>>> tb/tb_stepper_ramp_sequencer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_stepper_ramp_sequencer_core: self-checking bench for the ramp sequencer
// Streams timer ticks with random restart presses through the core, predicts
// every result with a cycle-free model of the ramp, and compares coil
// pattern, running and stepped flags. Delay registers are changed between
// phases: extremes first, then many short random ramps that stop and restart.
// ---------------------------------------------------------------------------
module tb_stepper_ramp_sequencer_core;
    import srs_pkg::*;

    // delay register range and counter ceiling at the block's width
    localparam int DELAY_LO  = -(1 << (DELAY_WIDTH - 1));
    localparam int DELAY_HI  = (1 << (DELAY_WIDTH - 1)) - 1;
    localparam logic [DELAY_WIDTH-1:0] TICK_CEIL = DELAY_WIDTH'(DELAY_HI);

    // coil patterns of the four full-step phases, phase 0 in the low nibble
    localparam logic [15:0] COIL_SEQ = {4'd5, 4'd6, 4'd10, 4'd9};

    // register indexes the block does not decode; writes there are dropped
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED_LO = CFG_IDX_WIDTH'(2);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED_HI = CFG_IDX_WIDTH'(3);

    localparam int MAX_PAUSE     = 13;   // longest per-request idle on either side
    localparam int HOLD_AT       = 200;  // result count that starts the long output stall
    localparam int HOLD_CYCLES   = 60;   // length of that stall
    localparam int SETTLE_CYCLES = 6;    // settling time past the two-stage path, plus margin
    localparam int RAND_TICKS    = 160;
    localparam int LONG_DELAY    = 60;   // flat ramp with long counts between steps

    typedef struct packed {
        logic [3:0] coil;
        logic       running;
        logic       stepped;
    } t_ramp_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic tick_valid = 1'b0;
    logic tick_button = 1'b0;
    logic res_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = REG_MAX_DELAY;
    logic signed [DELAY_WIDTH-1:0] cfg_data = '0;

    logic       o_in_ready;
    logic       o_out_valid;
    logic [3:0] o_coil_pattern;
    logic       o_running;
    logic       o_stepped;
    logic       o_cfg_ready;

    // predicted sequencer state and registers
    logic signed [DELAY_WIDTH-1:0] rmp_max = MAX_DELAY_RST;
    logic signed [DELAY_WIDTH-1:0] rmp_min = MIN_DELAY_RST;
    logic [DELAY_WIDTH-1:0]        rmp_tick = '0;
    logic signed [DELAY_WIDTH-1:0] rmp_delay = MAX_DELAY_RST;
    logic                          rmp_decel = 1'b0;
    logic                          rmp_active = 1'b1;
    logic [1:0]                    rmp_phase = 2'd0;
    logic [3:0]                    rmp_coil = 4'd0;

    logic         tick_q[$];          // pending button samples, one per tick request
    t_ramp_result coil_expect_q[$];   // predicted results in acceptance order

    int  ticks_queued = 0;
    int  ticks_sent = 0;
    int  results_checked = 0;
    int  error_count = 0;
    int  steps_issued = 0;
    int  ramp_stops = 0;
    int  ramp_restarts = 0;
    int  cfg_writes = 0;
    int  send_pause = 0;
    int  rcv_pause = 0;
    bit  send_calm = 1'b0;
    bit  rcv_calm = 1'b0;

    stepper_ramp_sequencer_core uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (tick_valid),
        .o_in_ready       (o_in_ready),
        .i_button_pressed (tick_button),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (res_ready),
        .o_coil_pattern   (o_coil_pattern),
        .o_running        (o_running),
        .o_stepped        (o_stepped),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length for one request; a calm side runs back to back.
    function automatic int pause_len(input bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_PAUSE));
    endfunction

    // Advance the ramp by one accepted tick and queue the result it produces.
    task automatic advance_ramp(input logic press);
        t_ramp_result r;
        r.stepped = 1'b0;
        if (rmp_active) begin
            // counter at or past the delay: issue the next coil pattern
            if ($signed({1'b0, rmp_tick}) >= rmp_delay) begin
                rmp_coil  = COIL_SEQ[rmp_phase*4 +: 4];
                rmp_phase = rmp_phase + 2'd1;
                r.stepped = 1'b1;
                steps_issued++;
                if (!rmp_decel) begin
                    // speed up until min_delay, then turn
                    if (rmp_delay > rmp_min)
                        rmp_delay = rmp_delay - DELAY_WIDTH'(1);
                    else
                        rmp_decel = 1'b1;
                end else begin
                    // slow down until max_delay, then stop
                    if (rmp_delay < rmp_max) begin
                        rmp_delay = rmp_delay + DELAY_WIDTH'(1);
                    end else begin
                        rmp_decel  = 1'b0;
                        rmp_active = 1'b0;
                        ramp_stops++;
                    end
                end
                rmp_tick = '0;
            end
            // saturate at the largest positive delay
            if (rmp_tick < TICK_CEIL)
                rmp_tick = rmp_tick + 1'b1;
        end else if (press) begin
            // restart at full delay; no step and no count on this tick
            rmp_delay  = rmp_max;
            rmp_tick   = '0;
            rmp_decel  = 1'b0;
            rmp_active = 1'b1;
            ramp_restarts++;
        end
        r.coil    = rmp_coil;
        r.running = rmp_active;
        coil_expect_q.push_back(r);
    endtask

    // Tick driver: offer queued requests, hold each until accepted, idle between.
    always @(posedge clk) begin : tick_driver
        logic nxt_valid;
        if (!rst_n) begin
            tick_valid <= 1'b0;
        end else begin
            nxt_valid = tick_valid;
            if (tick_valid && o_in_ready) begin
                advance_ramp(tick_button);
                ticks_sent++;
                nxt_valid = 1'b0;
                if ($urandom_range(0, 15) == 0)
                    send_calm = ~send_calm;
                send_pause = pause_len(send_calm);
            end
            if (!nxt_valid) begin
                if (send_pause > 0) begin
                    send_pause--;
                end else if (tick_q.size() > 0) begin
                    tick_button <= tick_q.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            tick_valid <= nxt_valid;
        end
    end

    // Result monitor: check each accepted result, then stall at random.
    always @(posedge clk) begin : result_monitor
        t_ramp_result want;
        logic         nxt_ready;
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            nxt_ready = 1'b1;
            if (o_out_valid && res_ready) begin
                if (coil_expect_q.size() == 0) begin
                    $error("result with no tick pending: coil_pattern %0d running %0b stepped %0b",
                           o_coil_pattern, o_running, o_stepped);
                    error_count++;
                end else begin
                    want = coil_expect_q.pop_front();
                    if (o_coil_pattern !== want.coil) begin
                        $error("coil_pattern: expected %0d, got %0d", want.coil, o_coil_pattern);
                        error_count++;
                    end
                    if (o_running !== want.running) begin
                        $error("running: expected %0b, got %0b", want.running, o_running);
                        error_count++;
                    end
                    if (o_stepped !== want.stepped) begin
                        $error("stepped: expected %0b, got %0b", want.stepped, o_stepped);
                        error_count++;
                    end
                    results_checked++;
                end
                if ($urandom_range(0, 15) == 0)
                    rcv_calm = ~rcv_calm;
                // one long hold-off so the core backs up and drops in_ready
                rcv_pause = (results_checked == HOLD_AT) ? HOLD_CYCLES : pause_len(rcv_calm);
                nxt_ready = (rcv_pause == 0);
            end else if (rcv_pause > 0) begin
                rcv_pause--;
                nxt_ready = (rcv_pause == 0);
            end
            res_ready <= nxt_ready;
        end
    end

    // Queue n ticks; each press drawn with odds press_odds in 8.
    task automatic queue_ticks(input int n, input int press_odds, input bit lead_press);
        for (int k = 0; k < n; k++)
            tick_q.push_back((k == 0 && lead_press) || (int'($urandom_range(1, 8)) <= press_odds));
        ticks_queued += n;
    endtask

    task automatic wait_sent();
        while (ticks_sent != ticks_queued)
            @(posedge clk);
    endtask

    // Hold until every tick is accepted and every result is back, then settle.
    task automatic wait_drained();
        while (ticks_sent != ticks_queued || results_checked != ticks_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[DELAY_WIDTH-1:0];
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MAX_DELAY)
            rmp_max = value[DELAY_WIDTH-1:0];
        else if (idx == REG_MIN_DELAY)
            rmp_min = value[DELAY_WIDTH-1:0];
        cfg_writes++;
    endtask

    // Bring a running ramp to a stop fast: with min above max and max at the
    // bottom, the ramp turns on its next step and stops on the one after.
    task automatic park_ramp();
        write_reg(REG_MAX_DELAY, DELAY_LO);
        write_reg(REG_MIN_DELAY, DELAY_HI);
        while (rmp_active) begin
            queue_ticks(16, 0, 1'b0);
            wait_sent();
        end
        wait_drained();
    endtask

    // One phase: drain, maybe park, set the delays, then stream n ticks that
    // open with a press so a stopped ramp starts again at once.
    task automatic run_profile(input int top, input int turn, input bit set_top,
                               input bit set_turn, input int n, input int press_odds);
        wait_drained();
        if (rmp_active && (int'(rmp_delay) > 16 || int'(rmp_delay) < -16 ||
                           $urandom_range(0, 2) == 0))
            park_ramp();
        if (set_top)
            write_reg(REG_MAX_DELAY, top);
        if (set_turn)
            write_reg(REG_MIN_DELAY, turn);
        queue_ticks(n, press_odds, 1'b1);
    endtask

    initial begin : stimulus
        int top;
        int turn;
        int n;
        int pick;
        int rand_ticks;
        rand_ticks = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset delays: presses while running must be ignored
        queue_ticks(10, 4, 1'b1);
        // flat slow ramp: long counts between steps, turn, then stop
        run_profile(LONG_DELAY, LONG_DELAY, 1'b1, 1'b1, 2 * LONG_DELAY + 10, 0);
        // most negative delays: step every tick, turn at once, stop, restart
        run_profile(DELAY_LO, DELAY_LO, 1'b1, 1'b1, 10, 4);
        // min above max
        run_profile(3, 6, 1'b1, 1'b1, 10, 3);
        // undecoded indexes must leave both delays alone
        wait_drained();
        write_reg(CFG_UNUSED_LO, -342);
        write_reg(CFG_UNUSED_HI, 341);
        run_profile(4, 0, 1'b1, 1'b1, 12, 2);

        // short random ramps that run out, stop and get restarted
        while (rand_ticks < RAND_TICKS) begin
            top  = int'($urandom_range(0, 12)) - 4;
            turn = top + 2 - int'($urandom_range(0, 10));
            n    = int'($urandom_range(30, 90));
            pick = int'($urandom_range(0, 3));
            run_profile(top, turn, pick != 1, pick != 0, n, int'($urandom_range(1, 4)));
            rand_ticks += n;
        end

        wait_drained();
        $display("Covered %0d ticks over %0d register writes: %0d coil steps, %0d ramp stops, %0d restarts.",
                 ticks_sent, cfg_writes, steps_issued, ramp_stops, ramp_restarts);
        if (error_count == 0)
            $display("tb_stepper_ramp_sequencer_core: PASS");
        else
            $display("tb_stepper_ramp_sequencer_core: FAIL");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_stepper_ramp_sequencer_core: FAIL");
        $finish;
    end

endmodule
